// ===== design/hbfa_pkg.sv =====
`timescale 1ns / 1ps

package hbfa_pkg;

    localparam int ATOM_COUNT    = 1024;
    localparam int TYPE_COUNT    = 256;
    localparam int FRACTION_BITS = 16;
    localparam int AW            = $clog2(ATOM_COUNT);
    localparam int TW            = $clog2(TYPE_COUNT);
    localparam int POS_W         = 32;
    localparam int COEF_W        = 32;
    localparam int FORCE_W       = 48;
    localparam int DEL_W         = POS_W + 1;
    localparam int RSQ_W         = 68;
    localparam int ROOT_W        = RSQ_W / 2;
    localparam int SQRT_STEPS    = RSQ_W / 2;
    localparam int NUM_W         = DEL_W + FRACTION_BITS;
    localparam int DIV_STEPS     = NUM_W;
    localparam int U_W           = FRACTION_BITS + 1;
    localparam int T_W           = ROOT_W + COEF_W - FRACTION_BITS;
    localparam int C_W           = T_W + U_W - FRACTION_BITS + 1;
    localparam int CS_W          = C_W + 1;
    localparam int SUM_W         = CS_W + 1;
    localparam int CNT_W         = 6;
    localparam int IN_W          = 192;
    localparam int OUT_W         = 3 * FORCE_W;

    localparam logic [1:0] MODE_LOAD_POS  = 2'd0;
    localparam logic [1:0] MODE_LOAD_TYPE = 2'd1;
    localparam logic [1:0] MODE_APPLY     = 2'd2;
    localparam logic [1:0] MODE_READ      = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DEL,
        ST_SQ,
        ST_SQRT,
        ST_TMUL,
        ST_DIV,
        ST_CMUL,
        ST_FRD,
        ST_FWA,
        ST_FWB
    } state_t;

    function automatic logic [FORCE_W-1:0] sat_add(input logic [FORCE_W-1:0] acc,
                                                   input logic [CS_W-1:0] d);
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] smax;
        logic signed [SUM_W-1:0] smin;
        begin
            s    = $signed({{(SUM_W-FORCE_W){acc[FORCE_W-1]}}, acc})
                 + $signed({{(SUM_W-CS_W){d[CS_W-1]}}, d});
            smax = $signed({{(SUM_W-FORCE_W+1){1'b0}}, {(FORCE_W-1){1'b1}}});
            smin = $signed({{(SUM_W-FORCE_W+1){1'b1}}, {(FORCE_W-1){1'b0}}});
            if (s > smax) begin
                sat_add = smax[FORCE_W-1:0];
            end else if (s < smin) begin
                sat_add = smin[FORCE_W-1:0];
            end else begin
                sat_add = s[FORCE_W-1:0];
            end
        end
    endfunction

endpackage

// ===== design/harmonic_bond_force_accumulator.sv =====
`timescale 1ns / 1ps
// Load position and load bond type items are written to memory as they are accepted.
// A read force item reads the force memory into a register, then loads the output register once the output is free.
// An apply bond item runs 34 square root steps and 49 divider steps for the
// direction cosines; force updates then read, modify and write the force
// memory for each local atom. It ends early if neither atom is local or the distance is zero.
// After reset a pass over all 1024 position entries clears them, local flags included; no item is taken then.
module harmonic_bond_force_accumulator (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // atom_a, atom_b, type_idx, pos_x, pos_y, pos_z, is_local, stiffness, rest_length
    input  logic [hbfa_pkg::IN_W-1:0] s_tdata,
    // mode
    input  logic [1:0]                s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // force_x, force_y, force_z
    output logic [hbfa_pkg::OUT_W-1:0] m_tdata
);
    import hbfa_pkg::*;

    localparam int PE_W = 3 * POS_W + 1;

    logic [AW-1:0]        s_a;
    logic [AW-1:0]        s_b;
    logic [TW-1:0]        s_ty;
    logic [3*POS_W-1:0]   s_pos;
    logic                 s_loc;
    logic [COEF_W-1:0]    s_k;
    logic [COEF_W-1:0]    s_r0;
    logic                 accept;

    assign s_a    = s_tdata[9:0];
    assign s_b    = s_tdata[19:10];
    assign s_ty   = s_tdata[27:20];
    assign s_pos  = s_tdata[123:28];
    assign s_loc  = s_tdata[124];
    assign s_k    = s_tdata[156:125];
    assign s_r0   = s_tdata[188:157];
    assign accept = s_tvalid && s_tready;

    logic [PE_W-1:0]      pos_mem [ATOM_COUNT];
    logic [2*COEF_W-1:0]  type_mem [TYPE_COUNT];
    logic [OUT_W-1:0]     force_mem [ATOM_COUNT];

    logic [PE_W-1:0]      pa_q, pb_q;
    logic [2*COEF_W-1:0]  ty_q;
    logic [OUT_W-1:0]     fa_q, fb_q;

    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [AW-1:0]        a_reg, b_reg;
    logic                 la_reg, lb_reg;
    logic [COEF_W-1:0]    k_reg, r0_reg;
    logic [DEL_W-1:0]     md_reg [3];
    logic                 dn_reg [3];
    logic [RSQ_W-1:0]     rsq_reg;
    logic [RSQ_W-1:0]     rsq_sh_reg;
    logic [ROOT_W+1:0]    sq_rem_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic                 delr_neg_reg;
    logic [T_W-1:0]       t_reg;
    logic [NUM_W-1:0]     num_reg [3];
    logic [ROOT_W-1:0]    drem_reg [3];
    logic [NUM_W-1:0]     q_reg [3];
    logic [CS_W-1:0]      cs_reg [3];
    logic                 m_tvalid_reg;
    logic [OUT_W-1:0]     m_tdata_reg;

    logic                 pos_we;
    logic [AW-1:0]        pos_waddr;
    logic [PE_W-1:0]      pos_wdata;
    logic                 f_we;
    logic [AW-1:0]        f_waddr;
    logic [OUT_W-1:0]     f_wdata;
    logic                 f_re;
    logic [AW-1:0]        f_raddr;
    logic                 out_load;
    logic                 out_free;

    logic [ROOT_W+3:0]    sq_cand;
    logic [ROOT_W+3:0]    sq_trial;
    logic [OUT_W-1:0]     fa_new, fb_new;

    assign out_free = !m_tvalid_reg || m_tready;
    assign sq_cand  = {sq_rem_reg, rsq_sh_reg[RSQ_W-1 -: 2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            fa_new[i*FORCE_W +: FORCE_W] = sat_add(fa_q[i*FORCE_W +: FORCE_W], cs_reg[i]);
            fb_new[i*FORCE_W +: FORCE_W] = sat_add(fb_q[i*FORCE_W +: FORCE_W],
                                                   CS_W'(0) - cs_reg[i]);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == AW'(ATOM_COUNT - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && s_tuser == MODE_READ) state_next = ST_READ;
                else if (accept && s_tuser == MODE_APPLY) state_next = ST_DEL;
            end
            ST_READ: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_DEL: begin
                if (!pa_q[PE_W-1] && !pb_q[PE_W-1]) state_next = ST_IDLE;
                else state_next = ST_SQ;
            end
            ST_SQ: begin
                if (cnt_reg == CNT_W'(2)) state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) state_next = ST_TMUL;
            end
            ST_TMUL: begin
                if (root_reg == '0) state_next = ST_IDLE;
                else state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = ST_CMUL;
            end
            ST_CMUL: begin
                if (cnt_reg == CNT_W'(2)) state_next = ST_FRD;
            end
            ST_FRD:  state_next = ST_FWA;
            ST_FWA:  state_next = ST_FWB;
            ST_FWB:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        pos_we    = 1'b0;
        pos_waddr = s_a;
        pos_wdata = {s_loc, s_pos};
        f_we      = 1'b0;
        f_waddr   = s_a;
        f_wdata   = '0;
        f_re      = 1'b0;
        f_raddr   = s_a;
        out_load  = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                pos_we   = accept && s_tuser == MODE_LOAD_POS;
                f_we     = accept && s_tuser == MODE_LOAD_POS;
                f_re     = accept && s_tuser == MODE_READ;
            end
            ST_READ: begin
                out_load = out_free;
            end
            ST_FRD: begin
                f_re    = 1'b1;
                f_raddr = a_reg;
            end
            ST_FWA: begin
                f_we    = la_reg;
                f_waddr = a_reg;
                f_wdata = fa_new;
            end
            ST_FWB: begin
                f_we    = lb_reg;
                f_waddr = b_reg;
                f_wdata = fb_new;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
        if (accept) begin
            pa_q <= pos_mem[s_a];
            pb_q <= pos_mem[s_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tuser == MODE_LOAD_TYPE) type_mem[s_ty] <= {s_r0, s_k};
        if (accept) ty_q <= type_mem[s_ty];
    end

    always_ff @(posedge aclk) begin
        if (f_we) force_mem[f_waddr] <= f_wdata;
        if (f_re) begin
            fa_q <= force_mem[f_raddr];
            fb_q <= force_mem[b_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + AW'(1);
            if (out_load) m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) m_tdata_reg <= fa_q;
        case (state_reg)
            ST_IDLE: begin
                a_reg   <= s_a;
                b_reg   <= s_b;
                cnt_reg <= '0;
            end
            ST_DEL: begin
                la_reg  <= pa_q[PE_W-1];
                lb_reg  <= pb_q[PE_W-1];
                k_reg   <= ty_q[COEF_W-1:0];
                r0_reg  <= ty_q[2*COEF_W-1:COEF_W];
                rsq_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    logic signed [DEL_W-1:0] d;
                    d = $signed({pa_q[i*POS_W+POS_W-1], pa_q[i*POS_W +: POS_W]})
                      - $signed({pb_q[i*POS_W+POS_W-1], pb_q[i*POS_W +: POS_W]});
                    dn_reg[i] <= d[DEL_W-1];
                    md_reg[i] <= d[DEL_W-1] ? DEL_W'(0) - DEL_W'(d) : DEL_W'(d);
                end
            end
            ST_SQ: begin
                rsq_reg <= rsq_reg + RSQ_W'(md_reg[cnt_reg[1:0]] * md_reg[cnt_reg[1:0]]);
                if (cnt_reg == CNT_W'(2)) begin
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                rsq_sh_reg <= rsq_reg + RSQ_W'(md_reg[cnt_reg[1:0]] * md_reg[cnt_reg[1:0]]);
                sq_rem_reg <= '0;
                root_reg   <= '0;
            end
            ST_SQRT: begin
                rsq_sh_reg <= rsq_sh_reg << 2;
                if (sq_cand >= sq_trial) begin
                    sq_rem_reg <= (ROOT_W+2)'(sq_cand - sq_trial);
                    root_reg   <= {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    sq_rem_reg <= sq_cand[ROOT_W+1:0];
                    root_reg   <= {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) begin
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            ST_TMUL: begin
                logic [ROOT_W-1:0] mdr;
                logic [ROOT_W+COEF_W-1:0] prod;
                mdr  = (root_reg < ROOT_W'(r0_reg)) ? ROOT_W'(r0_reg) - root_reg
                                                    : root_reg - ROOT_W'(r0_reg);
                prod = mdr * k_reg;
                delr_neg_reg <= root_reg < ROOT_W'(r0_reg);
                t_reg        <= prod[ROOT_W+COEF_W-1:FRACTION_BITS];
                for (int i = 0; i < 3; i++) begin
                    num_reg[i]  <= {md_reg[i], {FRACTION_BITS{1'b0}}};
                    drem_reg[i] <= '0;
                    q_reg[i]    <= '0;
                end
            end
            ST_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    logic [ROOT_W:0] tr;
                    tr = {drem_reg[i], num_reg[i][NUM_W-1]};
                    num_reg[i] <= num_reg[i] << 1;
                    if (tr >= {1'b0, root_reg}) begin
                        drem_reg[i] <= ROOT_W'(tr - {1'b0, root_reg});
                        q_reg[i]    <= {q_reg[i][NUM_W-2:0], 1'b1};
                    end else begin
                        drem_reg[i] <= tr[ROOT_W-1:0];
                        q_reg[i]    <= {q_reg[i][NUM_W-2:0], 1'b0};
                    end
                end
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            ST_CMUL: begin
                logic [T_W+U_W-1:0] p;
                logic [CS_W-1:0] c;
                p = t_reg * q_reg[cnt_reg[1:0]][U_W-1:0];
                c = {1'b0, p[T_W+U_W-1:FRACTION_BITS], 1'b0};
                cs_reg[cnt_reg[1:0]] <= (delr_neg_reg == dn_reg[cnt_reg[1:0]])
                                        ? CS_W'(0) - c : c;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
